// File: rtl/sliding_mad_outlier_remover_macros.svh
// ----------------------------------------------------------------------------
// sliding_mad_outlier_remover_macros.svh
// assertion macros for the outlier remover, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef SLIDING_MAD_OUTLIER_REMOVER_MACROS_SVH
`define SLIDING_MAD_OUTLIER_REMOVER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication on clk, disabled in reset
`define SMOR_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication on clk, disabled in reset
`define SMOR_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SMOR_ASSERT_IMPL(name, ante, cons, msg)
`define SMOR_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

// File: rtl/smor_pkg.sv
// ----------------------------------------------------------------------------
// smor_pkg
// shared constants and types of the sliding-window outlier remover
// ----------------------------------------------------------------------------
package smor_pkg;

	localparam int WINDOW_DEF = 11;
	localparam int X_W        = 32;
	localparam int Y_W        = 32;
	localparam int KEY_W      = 32;
	localparam int SCALE_W    = 13;
	localparam int PROD_W     = KEY_W + SCALE_W;

	// 0.6745 * |y - m| > 3.5 * mad  as  1349 * |y - m| > 7000 * mad
	localparam logic [SCALE_W-1:0] DEV_SCALE = SCALE_W'(1349);
	localparam logic [SCALE_W-1:0] MAD_SCALE = SCALE_W'(7000);

	typedef struct packed {
		logic busy;
		logic done;
	} rank_sts_t;

endpackage

// File: rtl/smor_ram.sv
// ----------------------------------------------------------------------------
// smor_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module smor_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr_a,
	output logic [WIDTH-1:0]  rd_data_a,
	input  logic [ADDR_W-1:0] rd_addr_b,
	output logic [WIDTH-1:0]  rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule

// File: rtl/smor_rank.sv
// ----------------------------------------------------------------------------
// smor_rank
// median search by pairwise rank counting, one compare per cycle
// ----------------------------------------------------------------------------
module smor_rank import smor_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF,
	localparam int AW = $clog2(WINDOW)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] key_a,
	input  logic [KEY_W-1:0] key_b,
	output logic [AW-1:0]    addr_a,
	output logic [AW-1:0]    addr_b,
	output rank_sts_t        sts,
	output logic [KEY_W-1:0] sel_key
);

	localparam int CW = $clog2(WINDOW + 1);
	localparam int H  = WINDOW / 2;

	logic             busy_q;
	logic [AW-1:0]    i_q;
	logic [AW-1:0]    j_q;
	logic             vld_s1;
	logic             jend_s1;
	logic             iend_s1;
	logic [CW-1:0]    acc_lt_q;
	logic [CW-1:0]    acc_le_q;
	logic             done_q;
	logic [KEY_W-1:0] sel_q;

	logic          lt;
	logic          le;
	logic [CW-1:0] tot_lt;
	logic [CW-1:0] tot_le;
	logic          hit;

	always_comb begin
		lt     = key_b < key_a;
		le     = key_b <= key_a;
		tot_lt = acc_lt_q + CW'(lt);
		tot_le = acc_le_q + CW'(le);
		hit    = (tot_lt <= CW'(H)) && (tot_le > CW'(H));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			i_q      <= '0;
			j_q      <= '0;
			vld_s1   <= 1'b0;
			jend_s1  <= 1'b0;
			iend_s1  <= 1'b0;
			acc_lt_q <= '0;
			acc_le_q <= '0;
			done_q   <= 1'b0;
		end else begin
			vld_s1  <= busy_q;
			jend_s1 <= j_q == AW'(WINDOW - 1);
			iend_s1 <= (i_q == AW'(WINDOW - 1)) && (j_q == AW'(WINDOW - 1));
			done_q  <= vld_s1 && iend_s1;
			if (start) begin
				busy_q   <= 1'b1;
				i_q      <= '0;
				j_q      <= '0;
				acc_lt_q <= '0;
				acc_le_q <= '0;
			end else if (busy_q) begin
				if (j_q == AW'(WINDOW - 1)) begin
					j_q <= '0;
					if (i_q == AW'(WINDOW - 1)) begin
						busy_q <= 1'b0;
					end else begin
						i_q <= i_q + AW'(1);
					end
				end else begin
					j_q <= j_q + AW'(1);
				end
			end
			if (vld_s1) begin
				if (jend_s1) begin
					acc_lt_q <= '0;
					acc_le_q <= '0;
				end else begin
					acc_lt_q <= tot_lt;
					acc_le_q <= tot_le;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && jend_s1 && hit) begin
			sel_q <= key_a;
		end
	end

	assign addr_a   = i_q;
	assign addr_b   = j_q;
	assign sts.busy = busy_q || vld_s1;
	assign sts.done = done_q;
	assign sel_key  = sel_q;

endmodule

// File: rtl/sliding_mad_outlier_remover.sv
// ----------------------------------------------------------------------------
// sliding_mad_outlier_remover
// hampel filter on a stream of (x, y) samples, median absolute deviation test
// ----------------------------------------------------------------------------
// Samples arrive one transfer at a time; in_last closes a sequence. A sample
// with a full window around it is dropped when 1349*|y-median| exceeds
// 7000*mad, edge samples pass unchanged. The block takes one sample at a time
// and is not ready while it works on it. For a sample that completes a full
// window, the median and the mad are each found by a rank scan that compares
// one pair of window entries per cycle through the two read ports of the
// window memory (for the mad, the deviation memory), then one shared
// multiplier forms both products. Each result takes a memory read and an
// output load, and waits while out_ready is low. The window memories need
// no clearing after reset.
// ----------------------------------------------------------------------------
`include "sliding_mad_outlier_remover_macros.svh"

module sliding_mad_outlier_remover import smor_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [X_W-1:0]        in_x,
	input  logic signed [Y_W-1:0] in_y,
	input  logic                  in_last,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [X_W-1:0]        out_x,
	output logic signed [Y_W-1:0] out_y,
	output logic                  out_last
);

	localparam int AW  = $clog2(WINDOW);
	localparam int CW  = $clog2(WINDOW + 1);
	localparam int PSW = CW + 1;
	localparam int H   = WINDOW / 2;

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_MED     = 9'b000000010,
		S_DEV     = 9'b000000100,
		S_MAD     = 9'b000001000,
		S_MUL_DEV = 9'b000010000,
		S_MUL_MAD = 9'b000100000,
		S_DECIDE  = 9'b001000000,
		S_RD      = 9'b010000000,
		S_OUT     = 9'b100000000
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic [AW-1:0]       head_q;
	logic                last_q;
	logic [CW-1:0]       emit_idx_q;
	logic [CW-1:0]       emit_end_q;
	logic [AW-1:0]       k_q;
	logic                k_run_q;
	logic                dev_vld_s1;
	logic [AW-1:0]       dev_idx_s1;
	logic signed [Y_W-1:0] med_q;
	logic [KEY_W-1:0]    dev_c_q;
	logic [PROD_W-1:0]   prod_dev_q;
	logic [PROD_W-1:0]   prod_mad_q;
	logic                out_valid_q;
	logic [X_W-1:0]      out_x_q;
	logic [Y_W-1:0]      out_y_q;
	logic                out_last_q;

	logic                accept;
	logic                lead;
	logic [CW-1:0]       cnt_next;
	logic [AW-1:0]       head_inc;
	logic [AW-1:0]       wr_addr;
	logic [PSW-1:0]      emit_sum;
	logic [PSW-1:0]      emit_wrap;
	logic [AW-1:0]       emit_phys;
	logic [PSW-1:0]      cen_sum;
	logic [PSW-1:0]      cen_wrap;
	logic [AW-1:0]       cen_phys;
	logic [AW-1:0]       win_addr_a;
	logic [X_W+Y_W-1:0]  win_rd_a;
	logic [X_W+Y_W-1:0]  win_rd_b;
	logic [KEY_W-1:0]    dev_rd_a;
	logic [KEY_W-1:0]    dev_rd_b;
	logic [KEY_W-1:0]    key_a;
	logic [KEY_W-1:0]    key_b;
	logic [AW-1:0]       rank_addr_a;
	logic [AW-1:0]       rank_addr_b;
	rank_sts_t           rank_sts;
	logic [KEY_W-1:0]    sel_key;
	logic                rank_start;
	logic [Y_W:0]        diff;
	logic [Y_W:0]        diff_neg;
	logic [KEY_W-1:0]    dev;
	logic [KEY_W-1:0]    mul_op;
	logic [SCALE_W-1:0]  mul_k;
	logic [PROD_W-1:0]   prod;
	logic                outlier;
	logic                out_free;
	logic                out_load;
	logic                dev_done;

	always_comb begin
		accept   = in_valid && in_ready;
		lead     = count_q < CW'(H);
		cnt_next = (count_q == CW'(WINDOW)) ? count_q : count_q + CW'(1);
		head_inc = (head_q == AW'(WINDOW - 1)) ? '0 : head_q + AW'(1);
		wr_addr  = (count_q == CW'(WINDOW)) ? head_q : count_q[AW-1:0];

		// logical index to physical slot of the circular window
		emit_sum  = PSW'(head_q) + PSW'(emit_idx_q);
		emit_wrap = (emit_sum >= PSW'(WINDOW)) ? emit_sum - PSW'(WINDOW) : emit_sum;
		emit_phys = emit_wrap[AW-1:0];
		cen_sum   = PSW'(head_q) + PSW'(H);
		cen_wrap  = (cen_sum >= PSW'(WINDOW)) ? cen_sum - PSW'(WINDOW) : cen_sum;
		cen_phys  = cen_wrap[AW-1:0];

		unique case (1'b1)
			state_q == S_MED: win_addr_a = rank_addr_a;
			state_q == S_DEV: win_addr_a = k_q;
			default:          win_addr_a = emit_phys;
		endcase

		// order-preserving unsigned key for signed values; deviations used as they are
		if (state_q == S_MAD) begin
			key_a = dev_rd_a;
			key_b = dev_rd_b;
		end else begin
			key_a = {~win_rd_a[Y_W-1], win_rd_a[Y_W-2:0]};
			key_b = {~win_rd_b[Y_W-1], win_rd_b[Y_W-2:0]};
		end

		diff     = {win_rd_a[Y_W-1], win_rd_a[Y_W-1:0]} - {med_q[Y_W-1], med_q};
		diff_neg = (Y_W + 1)'(0) - diff;
		dev      = diff[Y_W] ? diff_neg[KEY_W-1:0] : diff[KEY_W-1:0];
		dev_done = dev_vld_s1 && (dev_idx_s1 == AW'(WINDOW - 1));

		rank_start = (accept && !lead && (cnt_next == CW'(WINDOW)))
			|| (state_q == S_DEV && dev_done);

		mul_op  = (state_q == S_MUL_DEV) ? dev_c_q : sel_key;
		mul_k   = (state_q == S_MUL_DEV) ? DEV_SCALE : MAD_SCALE;
		prod    = PROD_W'(mul_op) * PROD_W'(mul_k);
		outlier = prod_dev_q > prod_mad_q;

		out_free = !out_valid_q || out_ready;
		out_load = (state_q == S_OUT) && out_free;
	end

	smor_ram #(
		.WIDTH(X_W + Y_W),
		.DEPTH(WINDOW)
	) u_win_ram (
		.clk      (clk),
		.wr_en    (accept),
		.wr_addr  (wr_addr),
		.wr_data  ({in_x, in_y}),
		.rd_addr_a(win_addr_a),
		.rd_data_a(win_rd_a),
		.rd_addr_b(rank_addr_b),
		.rd_data_b(win_rd_b)
	);

	smor_ram #(
		.WIDTH(KEY_W),
		.DEPTH(WINDOW)
	) u_dev_ram (
		.clk      (clk),
		.wr_en    (dev_vld_s1),
		.wr_addr  (dev_idx_s1),
		.wr_data  (dev),
		.rd_addr_a(rank_addr_a),
		.rd_data_a(dev_rd_a),
		.rd_addr_b(rank_addr_b),
		.rd_data_b(dev_rd_b)
	);

	smor_rank #(
		.WINDOW(WINDOW)
	) u_rank (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rank_start),
		.key_a  (key_a),
		.key_b  (key_b),
		.addr_a (rank_addr_a),
		.addr_b (rank_addr_b),
		.sts    (rank_sts),
		.sel_key(sel_key)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			last_q      <= 1'b0;
			emit_idx_q  <= '0;
			emit_end_q  <= '0;
			k_q         <= '0;
			k_run_q     <= 1'b0;
			dev_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			dev_vld_s1 <= (state_q == S_DEV) && k_run_q;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q  <= in_last;
						count_q <= cnt_next;
						if (count_q == CW'(WINDOW)) begin
							head_q <= head_inc;
						end
						if (lead) begin
							emit_idx_q <= count_q;
							emit_end_q <= count_q + CW'(1);
							state_q    <= S_RD;
						end else if (cnt_next == CW'(WINDOW)) begin
							state_q <= S_MED;
						end else if (in_last) begin
							emit_idx_q <= CW'(H);
							emit_end_q <= cnt_next;
							state_q    <= S_RD;
						end
					end
				end
				S_MED: begin
					if (rank_sts.done) begin
						k_q     <= '0;
						k_run_q <= 1'b1;
						state_q <= S_DEV;
					end
				end
				S_DEV: begin
					if (k_run_q) begin
						if (k_q == AW'(WINDOW - 1)) begin
							k_run_q <= 1'b0;
						end else begin
							k_q <= k_q + AW'(1);
						end
					end
					if (dev_done) begin
						state_q <= S_MAD;
					end
				end
				S_MAD: begin
					if (rank_sts.done) begin
						state_q <= S_MUL_DEV;
					end
				end
				S_MUL_DEV: state_q <= S_MUL_MAD;
				S_MUL_MAD: state_q <= S_DECIDE;
				S_DECIDE: begin
					emit_idx_q <= outlier ? CW'(H + 1) : CW'(H);
					emit_end_q <= last_q ? CW'(WINDOW) : CW'(H + 1);
					state_q    <= S_RD;
				end
				S_RD: begin
					if (emit_idx_q >= emit_end_q) begin
						state_q <= S_IDLE;
						if (last_q) begin
							count_q <= '0;
							head_q  <= '0;
						end
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						emit_idx_q <= emit_idx_q + CW'(1);
						state_q    <= S_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		dev_idx_s1 <= k_q;
		if (state_q == S_MED && rank_sts.done) begin
			med_q <= {~sel_key[KEY_W-1], sel_key[KEY_W-2:0]};
		end
		if (dev_vld_s1 && dev_idx_s1 == cen_phys) begin
			dev_c_q <= dev;
		end
		if (state_q == S_MUL_DEV) begin
			prod_dev_q <= prod;
		end
		if (state_q == S_MUL_MAD) begin
			prod_mad_q <= prod;
		end
		if (out_load) begin
			out_x_q    <= win_rd_a[X_W+Y_W-1:Y_W];
			out_y_q    <= win_rd_a[Y_W-1:0];
			out_last_q <= last_q && ((emit_idx_q + CW'(1)) == emit_end_q);
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_last  = out_last_q;

	`SMOR_ASSERT_IMPL(a_count_range, 1'b1, count_q <= CW'(WINDOW), "sample count beyond window")
	`SMOR_ASSERT_IMPL(a_head_filling, count_q != CW'(WINDOW), head_q == '0, "head moved before window full")
	`SMOR_ASSERT_IMPL(a_emit_bound, state_q == S_OUT, emit_idx_q < emit_end_q, "result index past end")
	`SMOR_ASSERT_NEXT(a_rank_idle_start, rank_start, rank_sts.busy, "rank scan did not start")

endmodule
